### sv/tcfs_pkg.sv
// Shared types, widths and constants for the triangle cull and flat shade block.
// No dependencies; every other file imports this package.
package tcfs_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COORD_FRAC  = COORD_WIDTH - 2;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int NRM_W       = PROD_W + 1;
  localparam int MAG_W       = NRM_W;
  localparam int NORM_BITS   = 30;
  localparam int SHIFT_W     = $clog2(((MAG_W > NORM_BITS) ? MAG_W : NORM_BITS) + 1);
  localparam int SUM_W       = 2 * NORM_BITS + 2;
  localparam int SQRT_STEPS  = NORM_BITS + 1;
  localparam int LEN_W       = NORM_BITS + 1;
  localparam int REM_W       = LEN_W + 1;
  localparam int LVL_W       = 16;
  localparam int DIV_STEPS   = LVL_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 1;

  localparam logic [MAG_W-1:0] CULL_LIMIT =
    MAG_W'((64'd1 << (2 * COORD_FRAC)) / 64'd1000000);
  localparam logic [LVL_W-1:0] LVL_FLOOR = 16'd1638;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_MODE   = 1'b0,
    REG_CULL_ENABLE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] aw;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by_coord;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] bw;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic signed [COORD_WIDTH-1:0] cw;
  } tcfs_tri_t;

  typedef struct packed {
    logic        visible;
    logic [31:0] argb_colour;
    logic [15:0] shade_level;
  } tcfs_res_t;

  // per-word control carried along the pipe
  typedef struct packed {
    logic vld;
    logic vis;
    logic shade;
  } tcfs_side_t;

  typedef struct packed {
    tcfs_side_t           side;
    logic [SUM_W-1:0]     v;
    logic [SUM_W-1:0]     res;
    logic [NORM_BITS-1:0] sz;
  } tcfs_sq_t;

  typedef struct packed {
    tcfs_side_t       side;
    logic [REM_W-1:0] r;
    logic [LEN_W-1:0] len;
    logic [LVL_W-1:0] q;
  } tcfs_dv_t;

  // trial bit of square root step k (largest first)
  function automatic logic [SUM_W-1:0] sqrt_bit(input int k);
    return SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
  endfunction

endpackage

### sv/tcfs_if.sv
// Valid/ready channel interfaces for triangle words and result words.
// Depends on tcfs_pkg.
interface tcfs_tri_if;
  import tcfs_pkg::*;
  logic      valid;
  logic      ready;
  tcfs_tri_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcfs_res_if;
  import tcfs_pkg::*;
  logic      valid;
  logic      ready;
  tcfs_res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/tcfs_front.sv
// Front pipe: edge vectors, face normal, cull test, normalization, sum of squares.
// Depends on tcfs_pkg.
module tcfs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                tri_vld,
  input  tcfs_pkg::tcfs_tri_t tri_data,
  input  logic                cull_enable,
  output tcfs_pkg::tcfs_sq_t  sq_o
);
  import tcfs_pkg::*;

  tcfs_side_t side1, side2, side3, side4, side5, side6, side7;
  logic signed [DIFF_W-1:0] d1x, d1y, d1z, d2x, d2y, d2z;
  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [NRM_W-1:0]  nx, ny, nz;
  logic [MAG_W-1:0] mx_c, my_c, mz_c, mx, my, mz, mx5, my5, mz5;
  logic [SHIFT_W-1:0] m_c, m5;
  logic [NORM_BITS-1:0] sx_c, sy_c, sz_c, sx, sy, sz, sz7;
  logic [2*NORM_BITS-1:0] qx, qy, qz;
  logic nz_neg, culled, any_nz;

  // stage 1: edge vectors, w test
  always_ff @(posedge clk) begin
    if (rst) begin
      side1 <= '0;
    end else if (adv) begin
      side1.vld   <= tri_vld;
      side1.vis   <= (tri_data.aw > 0) && (tri_data.bw > 0) && (tri_data.cw > 0);
      side1.shade <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d1x <= DIFF_W'(tri_data.bx) - DIFF_W'(tri_data.ax);
      d1y <= DIFF_W'(tri_data.by_coord) - DIFF_W'(tri_data.ay);
      d1z <= DIFF_W'(tri_data.bz) - DIFF_W'(tri_data.az);
      d2x <= DIFF_W'(tri_data.cx) - DIFF_W'(tri_data.ax);
      d2y <= DIFF_W'(tri_data.cy) - DIFF_W'(tri_data.ay);
      d2z <= DIFF_W'(tri_data.cz) - DIFF_W'(tri_data.az);
    end
  end

  // stage 2: six products; stage 3: normal
  always_ff @(posedge clk) begin
    if (rst) begin
      side2 <= '0;
      side3 <= '0;
    end else if (adv) begin
      side2 <= side1;
      side3 <= side2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= d1y * d2z;
      p1 <= d1z * d2y;
      p2 <= d1z * d2x;
      p3 <= d1x * d2z;
      p4 <= d1x * d2y;
      p5 <= d1y * d2x;
      nx <= NRM_W'(p0) - NRM_W'(p1);
      ny <= NRM_W'(p2) - NRM_W'(p3);
      nz <= NRM_W'(p4) - NRM_W'(p5);
    end
  end

  // stage 4: magnitudes and cull
  always_comb begin
    mx_c   = nx[NRM_W-1] ? MAG_W'(-nx) : MAG_W'(nx);
    my_c   = ny[NRM_W-1] ? MAG_W'(-ny) : MAG_W'(ny);
    mz_c   = nz[NRM_W-1] ? MAG_W'(-nz) : MAG_W'(nz);
    nz_neg = nz[NRM_W-1];
    any_nz = (|nx) || (|ny) || (|nz);
    culled = cull_enable && nz_neg && (mz_c > CULL_LIMIT);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      side4 <= '0;
    end else if (adv) begin
      side4.vld   <= side3.vld;
      side4.vis   <= side3.vis && !culled;
      side4.shade <= !nz_neg && any_nz;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mx <= mx_c;
      my <= my_c;
      mz <= mz_c;
    end
  end

  // stage 5: leading one of the largest magnitude
  always_comb begin
    m_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx[i] || my[i] || mz[i]) m_c = SHIFT_W'(i + 1);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      side5 <= '0;
    end else if (adv) begin
      side5 <= side4;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mx5 <= mx;
      my5 <= my;
      mz5 <= mz;
      m5  <= m_c;
    end
  end

  // stage 6: scale so the largest has NORM_BITS bits
  always_comb begin
    if (m5 > SHIFT_W'(NORM_BITS)) begin
      sx_c = NORM_BITS'(mx5 >> (m5 - SHIFT_W'(NORM_BITS)));
      sy_c = NORM_BITS'(my5 >> (m5 - SHIFT_W'(NORM_BITS)));
      sz_c = NORM_BITS'(mz5 >> (m5 - SHIFT_W'(NORM_BITS)));
    end else begin
      sx_c = NORM_BITS'(mx5 << (SHIFT_W'(NORM_BITS) - m5));
      sy_c = NORM_BITS'(my5 << (SHIFT_W'(NORM_BITS) - m5));
      sz_c = NORM_BITS'(mz5 << (SHIFT_W'(NORM_BITS) - m5));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      side6 <= '0;
      side7 <= '0;
    end else if (adv) begin
      side6 <= side5;
      side7 <= side6;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sx  <= sx_c;
      sy  <= sy_c;
      sz  <= sz_c;
      // stage 7: squares
      qx  <= sx * sx;
      qy  <= sy * sy;
      qz  <= sz * sz;
      sz7 <= sz;
    end
  end

  // stage 8: sum of squares, seeds the root chain
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_o.side <= '0;
    end else if (adv) begin
      sq_o.side <= side7;
      sq_o.v    <= SUM_W'(qx) + SUM_W'(qy) + SUM_W'(qz);
      sq_o.res  <= '0;
      sq_o.sz   <= sz7;
    end
  end

endmodule

### sv/tcfs_sqrt_cell.sv
// One digit of the integer square root; cells chain into the full root.
// Depends on tcfs_pkg.
module tcfs_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [tcfs_pkg::SUM_W-1:0]    trial,
  input  tcfs_pkg::tcfs_sq_t            sq_i,
  output tcfs_pkg::tcfs_sq_t            sq_o
);
  import tcfs_pkg::*;

  logic [SUM_W-1:0] cand;
  logic             take;

  always_comb begin
    cand = sq_i.res + trial;
    take = sq_i.v >= cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_o.side <= '0;
    end else if (adv) begin
      sq_o.side <= sq_i.side;
      sq_o.v    <= take ? sq_i.v - cand : sq_i.v;
      sq_o.res  <= take ? (sq_i.res >> 1) + trial : sq_i.res >> 1;
      sq_o.sz   <= sq_i.sz;
    end
  end

endmodule

### sv/tcfs_div_cell.sv
// One quotient bit of the restoring divide sz * 2^15 / len.
// Depends on tcfs_pkg.
module tcfs_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  tcfs_pkg::tcfs_dv_t dv_i,
  output tcfs_pkg::tcfs_dv_t dv_o
);
  import tcfs_pkg::*;

  logic             ge;
  logic [REM_W-1:0] rem;

  always_comb begin
    ge  = dv_i.r >= REM_W'(dv_i.len);
    rem = ge ? dv_i.r - REM_W'(dv_i.len) : dv_i.r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_o.side <= '0;
    end else if (adv) begin
      dv_o.side <= dv_i.side;
      dv_o.r    <= rem << 1;
      dv_o.len  <= dv_i.len;
      dv_o.q    <= {dv_i.q[LVL_W-2:0], ge};
    end
  end

endmodule

### sv/tcfs_out.sv
// Colour packing, output register and skid word.
// Depends on tcfs_pkg.
module tcfs_out (
  input  logic                clk,
  input  logic                rst,
  input  tcfs_pkg::tcfs_dv_t  dv_i,
  input  logic                fill_mode,
  output logic                adv,
  output logic                out_vld,
  input  logic                out_rdy,
  output tcfs_pkg::tcfs_res_t out_data,
  output logic                skid_vld
);
  import tcfs_pkg::*;

  tcfs_res_t        new_res, skid_data;
  logic [LVL_W-1:0] lvl_raw, lvl;
  logic [LVL_W+7:0] pr, pg;
  logic             pipe_go, out_free;

  always_comb begin
    lvl_raw = dv_i.side.shade ? dv_i.q : '0;
    lvl     = (lvl_raw < LVL_FLOOR) ? LVL_FLOOR : lvl_raw;
    pr      = (LVL_W+8)'(lvl) * (LVL_W+8)'(100);
    pg      = (LVL_W+8)'(lvl) * (LVL_W+8)'(255);
    new_res = '0;
    if (dv_i.side.vis) begin
      new_res.visible = 1'b1;
      if (!fill_mode) begin
        new_res.argb_colour = 32'hFFFF_FFFF;
      end else begin
        new_res.argb_colour = {8'hFF, pr[LVL_W+6:LVL_W-1], pg[LVL_W+6:LVL_W-1],
                               pg[LVL_W+6:LVL_W-1]};
        new_res.shade_level = lvl;
      end
    end
  end

  assign adv      = !skid_vld;
  assign pipe_go  = adv && dv_i.side.vld;
  assign out_free = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (out_free) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= pipe_go;
      end
    end else if (pipe_go) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_vld ? skid_data : new_res;
    end else if (pipe_go) begin
      skid_data <= new_res;
    end
  end

endmodule

### sv/triangle_cull_and_flat_shade_top.sv
// Triangle cull and flat shade: one triangle word in, one result word out.
// Pipeline: 8 front stages, 31 root cells, 16 divide cells and 1 output register.
// Throughput: one triangle per cycle; a held output parks one word in the skid stage,
// and input ready drops only while that skid word is full.
// Reset (rst, synchronous, active high): empties the pipe; fill_mode and cull_enable = 1.
// Depends on tcfs_pkg, tcfs_if, tcfs_front, tcfs_sqrt_cell, tcfs_div_cell, tcfs_out.
module triangle_cull_and_flat_shade_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tcfs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [tcfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  tcfs_tri_if.sink                            tri_in,
  tcfs_res_if.source                          res_out
);
  import tcfs_pkg::*;

  logic       fill_mode, cull_enable;
  logic       adv, skid_vld;
  tcfs_sq_t   sq [SQRT_STEPS+1];
  tcfs_dv_t   dv [DIV_STEPS+1];

  // config registers; the user must write them only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode   <= 1'b1;
      cull_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_FILL_MODE:   fill_mode   <= cfg_data[0];
        REG_CULL_ENABLE: cull_enable <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // the whole pipe moves together; it stalls only while the skid word holds
  assign tri_in.ready = adv;

  // edge vectors, normal, cull, scaling, sum of squares
  tcfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .tri_vld     (tri_in.valid),
    .tri_data    (tri_in.data),
    .cull_enable (cull_enable),
    .sq_o        (sq[0])
  );

  // root chain: one result bit per cell, largest trial bit first
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    tcfs_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .trial (sqrt_bit(k)),
      .sq_i  (sq[k]),
      .sq_o  (sq[k+1])
    );
  end

  // divide chain seeds: remainder = sz, divisor = normal length
  always_comb begin
    dv[0].side = sq[SQRT_STEPS].side;
    dv[0].r    = REM_W'(sq[SQRT_STEPS].sz);
    dv[0].len  = sq[SQRT_STEPS].res[LEN_W-1:0];
    dv[0].q    = '0;
  end

  // one quotient bit per cell, MSB first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    tcfs_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .dv_i (dv[k]),
      .dv_o (dv[k+1])
    );
  end

  // clamp, colour packing, output register and skid
  tcfs_out u_out (
    .clk       (clk),
    .rst       (rst),
    .dv_i      (dv[DIV_STEPS]),
    .fill_mode (fill_mode),
    .adv       (adv),
    .out_vld   (res_out.valid),
    .out_rdy   (res_out.ready),
    .out_data  (res_out.data),
    .skid_vld  (skid_vld)
  );

  // a parked skid word implies the output register is also full
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> res_out.valid)
    else $error("skid word held with empty output register");

  // rejected triangles carry no colour or level
  a_reject_clear: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && !res_out.data.visible) |->
      (res_out.data.argb_colour == 32'd0 && res_out.data.shade_level == 16'd0))
    else $error("rejected triangle with nonzero payload");

  // shaded result: level within floor..one, alpha opaque
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.data.visible && res_out.data.shade_level != 16'd0) |->
      (res_out.data.shade_level >= LVL_FLOOR && res_out.data.shade_level <= 16'd32768
       && res_out.data.argb_colour[31:24] == 8'hFF))
    else $error("shade level out of range");

endmodule

### tb/tb_triangle_cull_and_flat_shade_top.sv
// Self-checking testbench for triangle_cull_and_flat_shade_top.
// Depends on tcfs_pkg and tcfs_if; drives triangles, checks visibility, colour and shade.
module tb_triangle_cull_and_flat_shade_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcfs_pkg::*;

  localparam int   WATCHDOG_LIMIT = 5000;
  localparam int   DRAIN_CYCLES   = 60;
  localparam int   RAND_PER_PHASE = 140;
  localparam int   W_ONE          = 1 << COORD_FRAC;
  // back-facing tolerance: normal z has 2*COORD_FRAC fraction bits
  localparam longint BACK_TOL     = (64'd1 << (2 * COORD_FRAC)) / 64'd1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit   fill_mode = 1'b1;   // mirror of the block's registers
  bit   cull_enable = 1'b1;
  bit   calm = 1'b0;        // no idling on either side while set
  int   quiet_cycles = 0;

  tcfs_tri_if tri_ch ();
  tcfs_res_if res_ch ();

  triangle_cull_and_flat_shade_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .tri_in(tri_ch), .res_out(res_ch)
  );

  always #4 clk = ~clk;

  function automatic int bit_count(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned norm_scale(longint unsigned v, int s);
    if (s > 0) return v >> s;
    return v << (-s);
  endfunction

  // Expected result for one triangle under the given register settings.
  function automatic tcfs_res_t shade_triangle(tcfs_tri_t t, bit fill, bit cull);
    longint d1x, d1y, d1z, d2x, d2y, d2z, nx, ny, nz;
    longint unsigned mx, my, mz, sx, sy, sz, len, lvl;
    int m, s;
    tcfs_res_t r;
    r = '0;
    if ($signed(t.aw) <= 0 || $signed(t.bw) <= 0 || $signed(t.cw) <= 0) return r;
    d1x = longint'($signed(t.bx)) - longint'($signed(t.ax));
    d1y = longint'($signed(t.by_coord)) - longint'($signed(t.ay));
    d1z = longint'($signed(t.bz)) - longint'($signed(t.az));
    d2x = longint'($signed(t.cx)) - longint'($signed(t.ax));
    d2y = longint'($signed(t.cy)) - longint'($signed(t.ay));
    d2z = longint'($signed(t.cz)) - longint'($signed(t.az));
    nx = d1y * d2z - d1z * d2y;
    ny = d1z * d2x - d1x * d2z;
    nz = d1x * d2y - d1y * d2x;
    if (cull && nz < -BACK_TOL) return r;
    r.visible = 1'b1;
    if (!fill) begin
      r.argb_colour = 32'hFFFF_FFFF;
      return r;
    end
    mx = (nx < 0) ? -nx : nx;
    my = (ny < 0) ? -ny : ny;
    mz = (nz < 0) ? -nz : nz;
    m = bit_count(mx);
    if (bit_count(my) > m) m = bit_count(my);
    if (bit_count(mz) > m) m = bit_count(mz);
    lvl = 0;
    if (m > 0 && nz >= 0) begin
      s = m - NORM_BITS;
      sx = norm_scale(mx, s);
      sy = norm_scale(my, s);
      sz = norm_scale(mz, s);
      len = int_sqrt(sx * sx + sy * sy + sz * sz);
      if (len != 0 && sz != 0) lvl = (sz << 15) / len;
    end
    if (lvl < LVL_FLOOR) lvl = LVL_FLOOR;
    if (lvl > 32768) lvl = 32768;
    r.shade_level = lvl[15:0];
    r.argb_colour = {8'hFF, 8'((100 * lvl) >> 15), 8'((255 * lvl) >> 15),
                     8'((255 * lvl) >> 15)};
    return r;
  endfunction

  class shade_scoreboard;
    tcfs_res_t pending[$];
    int errors = 0;

    function void note_triangle(tcfs_tri_t t, bit fill, bit cull);
      pending = {pending, shade_triangle(t, fill, cull)};
    endfunction

    function void check_result(tcfs_res_t got);
      tcfs_res_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.visible !== exp.visible) begin
        $error("visible: expected %0d, got %0d", exp.visible, got.visible);
        errors++;
      end
      if (got.argb_colour !== exp.argb_colour) begin
        $error("argb_colour: expected %h, got %h", exp.argb_colour, got.argb_colour);
        errors++;
      end
      if (got.shade_level !== exp.shade_level) begin
        $error("shade_level: expected %0d, got %0d", exp.shade_level, got.shade_level);
        errors++;
      end
    endfunction
  endclass

  shade_scoreboard sb = new();

  initial begin
    tri_ch.valid = 1'b0;
    tri_ch.data  = '0;
    res_ch.ready = 1'b0;
  end

  // result side: check on accept, then pick next ready
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
    res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("triangle_cull_and_flat_shade_top regression: fail");
        $finish;
      end
    end
  end

  // one triangle word; valid stays high when words go back to back
  task automatic send_tri(tcfs_tri_t t);
    while (!calm && $urandom_range(99) < 22) begin
      tri_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tri_ch.valid <= 1'b1;
    tri_ch.data  <= t;
    do @(posedge clk); while (!tri_ch.ready);
    sb.note_triangle(t, fill_mode, cull_enable);
  endtask

  // hold off the sender until the pipe has emptied
  task automatic drain_pipe();
    tri_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == REG_FILL_MODE) fill_mode = val;
    else cull_enable = val;
  endtask

  function automatic tcfs_tri_t flat_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                         int z = 0);
    tcfs_tri_t t;
    t = '{ax: COORD_WIDTH'(ax), ay: COORD_WIDTH'(ay), az: COORD_WIDTH'(z),
          aw: COORD_WIDTH'(W_ONE), bx: COORD_WIDTH'(bx), by_coord: COORD_WIDTH'(by),
          bz: COORD_WIDTH'(z), bw: COORD_WIDTH'(W_ONE), cx: COORD_WIDTH'(cx),
          cy: COORD_WIDTH'(cy), cz: COORD_WIDTH'(z), cw: COORD_WIDTH'(W_ONE)};
    return t;
  endfunction

  function automatic logic [15:0] rnd_coord(int span);
    if (span == 0) return 16'($urandom);
    return 16'($urandom_range(2 * span) - span);
  endfunction

  // mostly drawable triangles with varied sizes; some bad w and degenerate ones
  function automatic tcfs_tri_t random_tri();
    tcfs_tri_t t;
    int span, kind;
    kind = $urandom_range(99);
    case ($urandom_range(3))
      0: span = 0;
      1: span = 300;
      2: span = 8000;
      default: span = 30;
    endcase
    t.ax = rnd_coord(span); t.ay = rnd_coord(span); t.az = rnd_coord(span);
    t.bx = rnd_coord(span); t.by_coord = rnd_coord(span); t.bz = rnd_coord(span);
    t.cx = rnd_coord(span); t.cy = rnd_coord(span); t.cz = rnd_coord(span);
    t.aw = 16'($urandom_range(32767, 1));
    t.bw = 16'($urandom_range(32767, 1));
    t.cw = 16'($urandom_range(32767, 1));
    if (kind < 12) begin
      // any w, including zero and negative
      t.aw = 16'($urandom); t.bw = 16'($urandom); t.cw = 16'($urandom);
    end else if (kind < 18) begin
      t.cx = t.ax; t.cy = t.ay; t.cz = t.az;   // zero-area triangle
    end
    return t;
  endfunction

  task automatic directed_set();
    tcfs_tri_t t;
    t = flat_tri(0, 0, 100, 0, 0, 100);
    send_tri(t);                                     // front facing, normal straight at viewer
    send_tri(flat_tri(0, 0, 0, 100, 100, 0));        // back facing
    send_tri(flat_tri(0, 0, 268, 0, 0, -1));         // just inside cull tolerance
    send_tri(flat_tri(0, 0, 269, 0, 0, -1));         // just beyond it
    send_tri(flat_tri(5, 5, 5, 5, 5, 5));            // zero normal
    send_tri(flat_tri(0, 0, 100, 0, 200, 0));        // collinear
    t.aw = '0; send_tri(t);                          // w zero on each vertex
    t = flat_tri(0, 0, 100, 0, 0, 100); t.bw = '0; send_tri(t);
    t = flat_tri(0, 0, 100, 0, 0, 100); t.cw = '0; send_tri(t);
    t = flat_tri(0, 0, 100, 0, 0, 100); t.aw = 16'h8000; send_tri(t);  // negative w
    t = flat_tri(0, 0, 100, 0, 0, 100); t.cw = 16'hFFFF; send_tri(t);
    t = flat_tri(0, 0, 100, 0, 0, 100); t.bw = 16'h7FFF; send_tri(t);
    // largest extents, both windings
    send_tri(flat_tri(-32768, -32768, 32767, -32768, -32768, 32767));
    send_tri(flat_tri(-32768, -32768, -32768, 32767, 32767, -32768));
    t = flat_tri(-32768, 32767, 32767, -32768, 32767, 32767, 0);
    t.az = 16'h8000; t.bz = 16'h7FFF; t.cz = 16'h0000;
    send_tri(t);
    // steep faces: tiny normal z against large x, y components
    t = flat_tri(0, 0, 1, 0, 0, 1); t.bz = 16'h7FFF; t.cz = 16'h8000; send_tri(t);
    t = flat_tri(0, 0, 0, 0, 1000, 0); t.bz = 16'h4000; t.cy = 16'd1; send_tri(t);
    send_tri(flat_tri(0, 0, 1, 0, 0, 1));            // smallest front face
    send_tri(flat_tri(0, 0, 0, 1, 1, 0));            // smallest back face
  endtask

  initial begin
    bit modes[5][2];
    modes = '{'{1, 1}, '{0, 1}, '{1, 0}, '{0, 0}, '{1, 1}};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      // registers change only with the pipe empty
      write_reg(REG_FILL_MODE, modes[ph][0]);
      write_reg(REG_CULL_ENABLE, modes[ph][1]);
      calm = (ph == 2);
      directed_set();
      for (int i = 0; i < RAND_PER_PHASE; i++) send_tri(random_tri());
      drain_pipe();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("triangle_cull_and_flat_shade_top regression: pass");
    else
      $display("triangle_cull_and_flat_shade_top regression: fail");
    $finish;
  end

endmodule
